// ----- rtl/core/hdlc_rx_deframer_fcs_check_unit_assert.svh -----
// assertion macros used by the receive deframer module
`ifndef HDLC_RX_DEFRAMER_FCS_CHECK_UNIT_ASSERT_SVH
`define HDLC_RX_DEFRAMER_FCS_CHECK_UNIT_ASSERT_SVH

// clocked assertion, off while reset is high
`define HDLCRX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define HDLCRX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/hdlcrx_pkg.sv -----
// ----------------------------------------------------------------------------
// hdlcrx_pkg
// types, constants and check functions of the hdlc receive deframer
// ----------------------------------------------------------------------------
package hdlcrx_pkg;

  // line codes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // register indexes
  localparam logic [7:0] REG_CHECK_MODE  = 8'd0;
  localparam logic [7:0] REG_FRAME_LIMIT = 8'd1;

  // sizes
  localparam int TAIL_DEPTH = 4;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam logic [15:0] FRAME_LIMIT_RST = 16'hFFFF;

  // polynomials, reflected
  localparam logic [31:0] POLY16 = 32'h0000_8408;
  localparam logic [31:0] POLY32 = 32'hEDB8_8320;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_SUM   = 2'd1,
    MODE_FCS16 = 2'd2,
    MODE_FCS32 = 2'd3
  } chk_mode_t;

  // control from the deframer to the check unit
  typedef struct packed {
    logic      start;
    logic      upd;
    chk_mode_t mode;
  } chk_ctrl_t;

  function automatic logic [2:0] check_len(chk_mode_t mode);
    logic [2:0] r;
    case (mode)
      MODE_SUM:   r = 3'd1;
      MODE_FCS16: r = 3'd2;
      MODE_FCS32: r = 3'd4;
      default:    r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] check_init(chk_mode_t mode);
    logic [31:0] r;
    case (mode)
      MODE_FCS16: r = 32'h0000_FFFF;
      MODE_FCS32: r = 32'hFFFF_FFFF;
      default:    r = 32'h0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] check_mask(chk_mode_t mode);
    logic [31:0] r;
    case (mode)
      MODE_SUM:   r = 32'h0000_00FF;
      MODE_FCS16: r = 32'h0000_FFFF;
      MODE_FCS32: r = 32'hFFFF_FFFF;
      default:    r = 32'h0;
    endcase
    return r;
  endfunction

  // fold one byte into the running check
  function automatic logic [31:0] check_update(chk_mode_t mode, logic [31:0] c,
                                               logic [7:0] b);
    logic [31:0] r;
    logic [7:0]  s;
    r = '0;
    s = c[7:0] + b;
    case (mode)
      MODE_SUM: begin
        r = {24'd0, s};
      end
      MODE_FCS16: begin
        r = {16'd0, c[15:0] ^ {8'd0, b}};
        for (int i = 0; i < 8; i++) begin
          r = r[0] ? ((r >> 1) ^ POLY16) : (r >> 1);
        end
      end
      MODE_FCS32: begin
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
          r = r[0] ? ((r >> 1) ^ POLY32) : (r >> 1);
        end
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/hdlcrx_chk.sv -----
// ----------------------------------------------------------------------------
// hdlcrx_chk
// running frame check (sum, fcs-16, fcs-32) and comparison with check bytes
// ----------------------------------------------------------------------------
module hdlcrx_chk
  import hdlcrx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  chk_ctrl_t   ctrl,
  input  logic [7:0]  data,
  input  logic [31:0] tail_word,
  output logic        mismatch
);

  logic [31:0] running;
  logic [31:0] running_next;

  // restart at frame open, fold emitted payload bytes
  always_comb begin
    running_next = running;
    if (ctrl.start) begin
      running_next = check_init(ctrl.mode);
    end else if (ctrl.upd) begin
      running_next = check_update(ctrl.mode, running, data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= check_init(MODE_FCS16);
    end else begin
      running <= running_next;
    end
  end

  // compare masked check with received check bytes
  assign mismatch = (running & check_mask(ctrl.mode)) != tail_word;

endmodule

// ----- rtl/core/hdlc_rx_deframer_fcs_check_unit.sv -----
// an accepted byte passes the input register, then the result register, before it shows as a result
// throughput: one line byte per cycle while results are taken; a waiting result stalls input
// a byte yields at most one result; a closing flag yields the frame end marker, while opening
// and empty-frame flags, escapes, hunt, overflow and the first check-length bytes yield none
// the check unit folds one byte per cycle while input advances, in a single combinational update
// reset: synchronous, hunting for flag, check_mode fcs-16, frame_limit 65535
// ----------------------------------------------------------------------------
// hdlc_rx_deframer_fcs_check_unit
// hdlc receive deframer: flag hunt, byte unstuffing, payload delay line,
// frame check and frame end report
// ----------------------------------------------------------------------------
`include "hdlc_rx_deframer_fcs_check_unit_assert.svh"

module hdlc_rx_deframer_fcs_check_unit
  import hdlcrx_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] out_byte, [8] frame_status,
                                 // [24:9] payload_len, [31:25] zero
  output logic        m_tlast,   // out_kind: frame end marker
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  // configuration
  chk_mode_t   check_mode;
  logic [15:0] frame_limit;

  // input register
  logic        in_valid;
  logic [7:0]  in_byte;

  // frame state
  logic                   in_frame, in_frame_next;
  logic                   esc, esc_next;
  logic [COUNT_WIDTH-1:0] count, count_next;
  logic [7:0]             tail [TAIL_DEPTH];
  logic [7:0]             tail_next [TAIL_DEPTH];
  chk_mode_t              frame_mode, frame_mode_next;

  // result register
  logic        out_valid;
  logic        out_last;
  logic [7:0]  out_byte;
  logic        out_status;
  logic [15:0] out_len;

  // per-item decode
  logic             advance;
  logic             proc;
  logic             res_valid;
  logic             res_last;
  logic [7:0]       res_byte;
  logic             res_status;
  logic [15:0]      res_len;
  logic [2:0]       k;
  logic [7:0]       v;
  logic [7:0]       emit;
  logic             can_emit;
  logic             store;
  logic             too_short;
  logic [31:0]      tail_word;
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] limit_ext;
  logic [COUNT_WIDTH-1:0] diff;
  logic [CMP_W-1:0] len_ext;
  chk_ctrl_t        chk_ctrl;
  logic             mismatch;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || m_tready;
  assign s_tready  = !in_valid || advance;
  assign proc      = in_valid && advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode  <= MODE_FCS16;
      frame_limit <= FRAME_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CHECK_MODE:  check_mode  <= chk_mode_t'(cfg_data[1:0]);
        REG_FRAME_LIMIT: frame_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register, refilled as it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // check field length and received check word, newest byte highest
  assign k         = check_len(frame_mode);
  assign count_ext = CMP_W'(count);
  assign limit_ext = CMP_W'(frame_limit);
  assign diff      = count - COUNT_WIDTH'(k);
  assign len_ext   = CMP_W'(diff);
  assign too_short = count < COUNT_WIDTH'(k);
  assign v         = esc ? (in_byte ^ ESC_XOR) : in_byte;

  always_comb begin
    case (frame_mode)
      MODE_SUM:   tail_word = {24'd0, tail[0]};
      MODE_FCS16: tail_word = {16'd0, tail[0], tail[1]};
      MODE_FCS32: tail_word = {tail[0], tail[1], tail[2], tail[3]};
      default:    tail_word = 32'd0;
    endcase
  end

  // byte leaving the delay line
  always_comb begin
    case (k)
      3'd1:    emit = tail[0];
      3'd2:    emit = tail[1];
      3'd4:    emit = tail[3];
      default: emit = v;
    endcase
    can_emit = (k == 3'd0) || !too_short;
  end

  // frame decode
  always_comb begin
    in_frame_next   = in_frame;
    esc_next        = esc;
    count_next      = count;
    frame_mode_next = frame_mode;
    for (int i = 0; i < TAIL_DEPTH; i++) begin
      tail_next[i] = tail[i];
    end
    store      = 1'b0;
    res_valid  = 1'b0;
    res_last   = 1'b0;
    res_byte   = 8'd0;
    res_status = 1'b0;
    res_len    = 16'd0;
    chk_ctrl.start = 1'b0;
    chk_ctrl.upd   = 1'b0;
    chk_ctrl.mode  = frame_mode;

    if (proc) begin
      if (!in_frame) begin
        // hunt: only an opening flag matters
        if (in_byte == FLAG_BYTE) begin
          in_frame_next   = 1'b1;
          esc_next        = 1'b0;
          count_next      = '0;
          frame_mode_next = check_mode;
          for (int i = 0; i < TAIL_DEPTH; i++) begin
            tail_next[i] = 8'd0;
          end
          chk_ctrl.start = 1'b1;
          chk_ctrl.mode  = check_mode;
        end
      end else if (in_byte == FLAG_BYTE) begin
        if (count == '0) begin
          // empty frame, resync only
          esc_next = 1'b0;
        end else begin
          in_frame_next = 1'b0;
          res_valid     = 1'b1;
          res_last      = 1'b1;
          res_status    = too_short || mismatch;
          res_len       = too_short ? 16'd0 : len_ext[15:0];
        end
      end else if (in_byte == ESC_BYTE) begin
        esc_next = 1'b1;
      end else if (!(count_ext >= limit_ext) && !(&count)) begin
        store      = 1'b1;
        esc_next   = 1'b0;
        count_next = count + COUNT_WIDTH'(1);
        for (int i = TAIL_DEPTH - 1; i > 0; i--) begin
          tail_next[i] = tail[i-1];
        end
        tail_next[0] = v;
        if (can_emit) begin
          res_valid    = 1'b1;
          res_byte     = emit;
          chk_ctrl.upd = 1'b1;
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      esc        <= 1'b0;
      count      <= '0;
      frame_mode <= MODE_FCS16;
      for (int i = 0; i < TAIL_DEPTH; i++) begin
        tail[i] <= 8'd0;
      end
    end else begin
      in_frame   <= in_frame_next;
      esc        <= esc_next;
      count      <= count_next;
      frame_mode <= frame_mode_next;
      for (int i = 0; i < TAIL_DEPTH; i++) begin
        tail[i] <= tail_next[i];
      end
    end
  end

  // running check
  hdlcrx_chk u_chk (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (chk_ctrl),
    .data      (emit),
    .tail_word (tail_word),
    .mismatch  (mismatch)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_last   <= res_last;
      out_byte   <= res_byte;
      out_status <= res_status;
      out_len    <= res_len;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {7'd0, out_len, out_status, out_byte};

  // checks
  `HDLCRX_ASSERT(a_no_overrun, in_valid && out_valid && !m_tready |-> !s_tready,
                 "input taken while both stages are full")
  `HDLCRX_ASSERT(a_accept_fills, s_tvalid && s_tready |=> in_valid,
                 "accepted request lost before the input register")
  `HDLCRX_ASSERT(a_end_fields, m_tvalid && m_tlast |-> m_tdata[7:0] == 8'd0,
                 "frame end marker carries a data byte")
  `HDLCRX_ASSERT(a_data_fields,
                 m_tvalid && !m_tlast |-> m_tdata[24:8] == 17'd0,
                 "payload byte carries status or length")
  `HDLCRX_ASSERT(a_store_counts, store |=> count == $past(count) + COUNT_WIDTH'(1),
                 "stored byte not counted")

endmodule

// ----- test/tb_hdlc_rx_deframer_fcs_check_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hdlc_rx_deframer_fcs_check_unit
// self-checking bench for the hdlc receive deframer: line bytes go in as a
// stream, a software deframer predicts every payload byte and frame end report
// ----------------------------------------------------------------------------
module tb_hdlc_rx_deframer_fcs_check_unit;
  import hdlcrx_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN       = 8;
  localparam int CNT_MAX     = 65535;
  localparam int NPH         = 9;
  localparam int BIG_PH      = 7;

  // one deframer output: payload byte or frame end report
  typedef struct {
    logic        is_end;
    logic [7:0]  data;
    logic        bad;
    logic [15:0] len;
  } rx_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;    // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [7:0] out_byte, [8] frame_status, [24:9] payload_len
  logic        m_tlast;           // out_kind
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = 8'd0;
  logic [15:0] cfg_data = 16'd0;

  hdlc_rx_deframer_fcs_check_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // line bytes waiting to be sent, expected deframer outputs
  logic [7:0] line_q [$];
  rx_out_t    rx_out_q [$];
  logic [7:0] body_q [$];
  int         n_put = 0;

  int err_cnt   = 0;
  int res_cnt   = 0;
  int stall_cnt = 0;
  bit in_fire   = 1'b0;
  bit idle_on   = 1'b1;
  int burst_left = 0;
  int gap_left   = 0;
  int rcv_cnt    = 0;
  int rcv_mode   = 0;

  // software deframer state
  chk_mode_t  p_mode  = MODE_FCS16;
  int         p_limit = 65535;
  chk_mode_t  p_fmode = MODE_FCS16;
  bit         p_in_frame = 1'b0;
  bit         p_esc = 1'b0;
  int         p_count = 0;
  logic [7:0] p_tail [0:3] = '{8'd0, 8'd0, 8'd0, 8'd0};
  logic [31:0] p_chk = 32'h0000_FFFF;

  // check field size, seed and compare mask per mode
  function automatic int fcs_len(chk_mode_t m);
    case (m)
      MODE_SUM:   return 1;
      MODE_FCS16: return 2;
      MODE_FCS32: return 4;
      default:    return 0;
    endcase
  endfunction

  function automatic logic [31:0] fcs_seed(chk_mode_t m);
    case (m)
      MODE_FCS16: return 32'h0000_FFFF;
      MODE_FCS32: return 32'hFFFF_FFFF;
      default:    return 32'h0;
    endcase
  endfunction

  function automatic logic [31:0] fcs_mask(chk_mode_t m);
    case (m)
      MODE_SUM:   return 32'h0000_00FF;
      MODE_FCS16: return 32'h0000_FFFF;
      MODE_FCS32: return 32'hFFFF_FFFF;
      default:    return 32'h0;
    endcase
  endfunction

  // fold one payload byte, bitwise reflected crc or byte sum
  function automatic logic [31:0] fold_byte(chk_mode_t m, logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    int i;
    r = '0;
    case (m)
      MODE_SUM: begin
        r = {24'd0, c[7:0] + b};
      end
      MODE_FCS16: begin
        r = {16'd0, c[15:0] ^ {8'd0, b}};
        for (i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ POLY16) : (r >> 1);
      end
      MODE_FCS32: begin
        r = c ^ {24'd0, b};
        for (i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ POLY32) : (r >> 1);
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  // deframe one accepted line byte, queue what it yields
  task automatic deframe_byte(input logic [7:0] b);
    rx_out_t    r;
    logic [7:0] v;
    logic [7:0] emit;
    logic [31:0] rd;
    int k;
    int i;
    bit hit;
    k = fcs_len(p_fmode);
    r.is_end = 1'b0;
    r.data = 8'd0;
    r.bad = 1'b0;
    r.len = 16'd0;
    emit = 8'd0;
    hit = 1'b0;
    if (!p_in_frame) begin
      // hunting: only a flag opens a frame
      if (b == FLAG_BYTE) begin
        p_in_frame = 1'b1;
        p_esc = 1'b0;
        p_count = 0;
        for (i = 0; i < 4; i++) p_tail[i] = 8'd0;
        p_fmode = p_mode;
        p_chk = fcs_seed(p_mode);
      end
    end else if (b == FLAG_BYTE) begin
      if (p_count == 0) begin
        // empty frame only resyncs
        p_esc = 1'b0;
      end else begin
        p_in_frame = 1'b0;
        r.is_end = 1'b1;
        if (p_count < k) begin
          r.bad = 1'b1;
        end else begin
          rd = 32'd0;
          for (i = 0; i < k; i++) rd = (rd << 8) | {24'd0, p_tail[i]};
          r.bad = ((p_chk & fcs_mask(p_fmode)) != rd);
          r.len = 16'(p_count - k);
        end
        rx_out_q.push_back(r);
      end
    end else if (b == ESC_BYTE) begin
      p_esc = 1'b1;
    end else if (p_count < p_limit && p_count < CNT_MAX) begin
      v = p_esc ? (b ^ ESC_XOR) : b;
      p_esc = 1'b0;
      // payload leaves the delay line once older than the check field
      if (k == 0) begin
        emit = v;
        hit = 1'b1;
      end else if (p_count >= k) begin
        emit = p_tail[k-1];
        hit = 1'b1;
      end
      for (i = 3; i > 0; i--) p_tail[i] = p_tail[i-1];
      p_tail[0] = v;
      p_count++;
      if (hit) begin
        p_chk = fold_byte(p_fmode, p_chk, emit);
        r.data = emit;
        rx_out_q.push_back(r);
      end
    end
  endtask

  task automatic note_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 100) $display("mismatch: %s", msg);
  endtask

  // compare one accepted result with the oldest expectation
  task automatic check_result();
    rx_out_t e;
    if (rx_out_q.size() == 0) begin
      note_mismatch($sformatf("result %0d with nothing expected, tdata %h tlast %b",
                              res_cnt, m_tdata, m_tlast));
    end else begin
      e = rx_out_q.pop_front();
      if (m_tlast !== e.is_end)
        note_mismatch($sformatf("result %0d out_kind %b, want %b", res_cnt, m_tlast, e.is_end));
      if (m_tdata[7:0] !== e.data)
        note_mismatch($sformatf("result %0d out_byte %h, want %h", res_cnt, m_tdata[7:0],
                                e.data));
      if (m_tdata[8] !== e.bad)
        note_mismatch($sformatf("result %0d frame_status %b, want %b", res_cnt, m_tdata[8],
                                e.bad));
      if (m_tdata[24:9] !== e.len)
        note_mismatch($sformatf("result %0d payload_len %0d, want %0d", res_cnt,
                                m_tdata[24:9], e.len));
      if (m_tdata[31:25] !== 7'd0)
        note_mismatch($sformatf("result %0d pad bits %b", res_cnt, m_tdata[31:25]));
    end
    res_cnt++;
  endtask

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // sample every request at the rising edge
  always @(posedge clk) begin
    in_fire = s_tvalid && s_tready && !rst;
    if (!rst) begin
      if (m_tvalid && m_tready) check_result();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CHECK_MODE:  p_mode = chk_mode_t'(cfg_data[1:0]);
          REG_FRAME_LIMIT: p_limit = int'(cfg_data);
          default: ;
        endcase
      end
      if (in_fire) deframe_byte(s_tdata);
    end
    // watchdog on cycles with no request at all
    if (in_fire || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // line byte driver, bursts with random gaps while idle_on is set
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (line_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= line_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          if (!idle_on) gap_left = 0;
          else if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(8, 16);
          else gap_left = $urandom_range(1, 4);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls, in a pattern that rcv_cnt periodically redraws at random
  always @(negedge clk) begin
    rcv_cnt++;
    if (rcv_cnt % 256 == 0) rcv_mode = $urandom_range(0, 3);
    case (rcv_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ((rcv_cnt % 16) < 5);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic put(input logic [7:0] b);
    line_q.push_back(b);
    n_put++;
  endtask

  // stuff a stored byte, sometimes escaping an ordinary one
  task automatic put_stuffed(input logic [7:0] v);
    if (v == FLAG_BYTE || v == ESC_BYTE ||
        ($urandom_range(0, 15) == 0 && (v ^ ESC_XOR) != FLAG_BYTE &&
         (v ^ ESC_XOR) != ESC_BYTE)) begin
      put(ESC_BYTE);
      put(v ^ ESC_XOR);
    end else begin
      put(v);
    end
  endtask

  function automatic logic [7:0] pay_byte();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  // flag, body_q with its check field, optional junk bytes, flag
  task automatic put_frame(input chk_mode_t fm, input bit corrupt, input int extra);
    logic [31:0] c;
    logic [7:0]  j;
    int i;
    int pos;
    int n;
    c = fcs_seed(fm);
    n = body_q.size();
    for (i = 0; i < n; i++) c = fold_byte(fm, c, body_q[i]);
    for (i = 0; i < fcs_len(fm); i++) body_q.push_back(c[8*i +: 8]);
    if (corrupt && body_q.size() > 0) begin
      pos = $urandom_range(0, body_q.size() - 1);
      body_q[pos] = body_q[pos] ^ 8'(1 << $urandom_range(0, 7));
    end
    put(FLAG_BYTE);
    for (i = 0; i < body_q.size(); i++) put_stuffed(body_q[i]);
    for (i = 0; i < extra; i++) begin
      j = 8'($urandom_range(0, 255));
      put((j == FLAG_BYTE || j == ESC_BYTE) ? 8'h00 : j);
    end
    put(FLAG_BYTE);
    body_q.delete();
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // all bytes sent, all results in, then a drain wait for trailing work
  task automatic wait_idle();
    while (line_q.size() != 0 || s_tvalid || rx_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // stimulus
  initial begin
    chk_mode_t ph_mode [NPH];
    int        ph_limit [NPH];
    int        ph_items [NPH];
    logic [15:0] d;
    int ph;
    int start;
    int kind;
    int len;
    int i;
    ph_mode  = '{MODE_NONE, MODE_SUM, MODE_FCS32, MODE_FCS16, MODE_FCS32,
                 MODE_SUM, MODE_NONE, MODE_FCS16, MODE_FCS16};
    ph_limit = '{1, 65535, 6, 0, 65535, 3, 65535, 65535, 40};
    ph_items = '{150, 200, 200, 60, 220, 150, 200, 100, 200};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part under reset settings: fcs-16, limit 65535
    put(8'hFF); put(8'h00); put(8'h55);
    put(FLAG_BYTE); put(FLAG_BYTE);
    put(ESC_BYTE); put(FLAG_BYTE);
    body_q = '{8'h00, FLAG_BYTE, 8'hFF};
    put_frame(MODE_FCS16, 1'b0, 0);
    put(FLAG_BYTE); put(8'hAB); put(FLAG_BYTE);
    put(FLAG_BYTE); put(8'h11); put(ESC_BYTE); put(ESC_BYTE);
    put(8'h22); put(8'h33); put(ESC_BYTE); put(FLAG_BYTE);
    wait_idle();

    for (ph = 0; ph < NPH; ph++) begin
      // settings change only while idle
      d = 16'($urandom_range(0, 65535));
      d[1:0] = ph_mode[ph];
      if (ph % 2 == 0) begin
        write_reg(REG_CHECK_MODE, d);
        write_reg(REG_FRAME_LIMIT, 16'(ph_limit[ph]));
      end else begin
        write_reg(REG_FRAME_LIMIT, 16'(ph_limit[ph]));
        write_reg(REG_CHECK_MODE, d);
      end
      if (ph % 3 == 1)
        write_reg(REG_FRAME_LIMIT + 8'($urandom_range(1, 254)), 16'($urandom_range(0, 65535)));
      idle_on = (ph % 3 != 2) && (ph != BIG_PH);

      start = n_put;
      while (n_put - start < ph_items[ph]) begin
        kind = $urandom_range(0, 19);
        if (kind < 14) begin
          // well-formed frames, a few corrupted
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
          for (i = 0; i < len; i++) body_q.push_back(pay_byte());
          put_frame(ph_mode[ph], kind >= 12,
                    ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0);
        end else if (kind < 16) begin
          // truncated frame without a check field
          len = $urandom_range(1, 3);
          for (i = 0; i < len; i++) body_q.push_back(pay_byte());
          put_frame(MODE_NONE, 1'b0, 0);
        end else if (kind < 18) begin
          // line noise rich in flags and escapes
          len = $urandom_range(3, 12);
          for (i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
              0, 1:    put(FLAG_BYTE);
              2, 3:    put(ESC_BYTE);
              4:       put(8'hFF);
              default: put(8'($urandom_range(0, 255)));
            endcase
          end
        end else begin
          case ($urandom_range(0, 2))
            0: begin
              put(FLAG_BYTE); put(FLAG_BYTE); put(FLAG_BYTE);
            end
            1: begin
              put(FLAG_BYTE); put(pay_byte()); put(ESC_BYTE); put(ESC_BYTE);
              put(8'($urandom_range(0, 125))); put(ESC_BYTE); put(FLAG_BYTE);
            end
            default: begin
              put(FLAG_BYTE); put(ESC_BYTE); put(FLAG_BYTE);
              len = $urandom_range(1, 8);
              for (i = 0; i < len; i++) body_q.push_back(pay_byte());
              put_frame(ph_mode[ph], 1'b0, 0);
            end
          endcase
        end
        // idle fill between frames
        len = $urandom_range(0, 2);
        for (i = 0; i < len; i++) put(8'hFF);
      end
      wait_idle();
    end

    if (rx_out_q.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", rx_out_q.size()));
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/hdlcrx_pkg.sv
rtl/core/hdlcrx_chk.sv
rtl/core/hdlc_rx_deframer_fcs_check_unit.sv
test/tb_hdlc_rx_deframer_fcs_check_unit.sv
